// File: src/lgs_pkg.sv
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int OP_W          = 2;
  localparam int COORD_W       = 6;
  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;
  localparam int NBR_W         = 4;
  localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_STEP  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_SET,
    WR_LIFE
  } wr_sel_t;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    logic    rd_item;
    logic    wr_en;
    logic    wr_item;
    wr_sel_t wr_sel;
    logic    win_clear;
    logic    win_shift;
    logic    nxt_zero;
    logic    load_out;
  } dp_cmd_t;

endpackage

// File: src/life_grid_generation_step_top.sv
`timescale 1ns / 1ps

// Game of life grid, rule B3/S23, non-wrapping edges.
// Input channel (in_valid/in_stall) carries op, row, col; one beat per op:
//   set cell alive, clear grid, advance one generation, read cell.
// Output channel (out_valid/out_stall) returns one beat per op: cell_alive,
// the addressed cell after the op (0 for an address outside the grid).
// One op is handled at a time; in_stall stays high until its result is
// written to the output register.
// The step sweeps the grid RAM one row per cycle through a three-row window,
// so its length follows the single row read port.
// A new op may be taken while the previous result still waits; if the
// receiver stalls, the next result holds in its last state until the output
// register drains.
// Reset starts a clearing pass that zeroes every row;
// in_stall stays high until it is done.
module life_grid_generation_step_top #(
  parameter int GRID_ROWS = lgs_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = lgs_pkg::DEF_GRID_COLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lgs_pkg::OP_W-1:0]    op,
  input  logic [lgs_pkg::COORD_W-1:0] row,
  input  logic [lgs_pkg::COORD_W-1:0] col,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        cell_alive
);

  import lgs_pkg::*;

  localparam int ROW_AW = $clog2(GRID_ROWS);

  dp_cmd_t           cmd;
  logic [ROW_AW-1:0] sweep_rd_addr;
  logic [ROW_AW-1:0] sweep_wr_addr;

  lgs_ctrl #(
    .GRID_ROWS (GRID_ROWS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .sweep_rd_addr (sweep_rd_addr),
    .sweep_wr_addr (sweep_wr_addr)
  );

  lgs_dp #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sweep_rd_addr (sweep_rd_addr),
    .sweep_wr_addr (sweep_wr_addr),
    .row           (row),
    .col           (col),
    .cell_alive    (cell_alive)
  );

endmodule

// File: src/lgs_ram.sv
`timescale 1ns / 1ps

module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/lgs_dp.sv
`timescale 1ns / 1ps

module lgs_dp #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  logic                           clk,
  input  lgs_pkg::dp_cmd_t               cmd,
  input  logic [$clog2(GRID_ROWS)-1:0]   sweep_rd_addr,
  input  logic [$clog2(GRID_ROWS)-1:0]   sweep_wr_addr,
  input  logic [lgs_pkg::COORD_W-1:0]    row,
  input  logic [lgs_pkg::COORD_W-1:0]    col,
  output logic                           cell_alive
);

  import lgs_pkg::*;

  localparam int ROW_AW = $clog2(GRID_ROWS);
  localparam int COL_AW = $clog2(GRID_COLS);
  localparam int RW     = (ROW_AW > COORD_W) ? ROW_AW : COORD_W;

  logic [COORD_W-1:0]   row_q;
  logic [COORD_W-1:0]   col_q;
  logic [GRID_COLS-1:0] prev_row;
  logic [GRID_COLS-1:0] cur_row;
  logic [GRID_COLS-1:0] nxt_row;
  logic [GRID_COLS-1:0] rd_data;
  logic [GRID_COLS-1:0] wr_data;
  logic [GRID_COLS-1:0] life_row;
  logic [GRID_COLS+1:0] pad_prev;
  logic [GRID_COLS+1:0] pad_cur;
  logic [GRID_COLS+1:0] pad_nxt;
  logic [RW-1:0]        row_ext;
  logic [ROW_AW-1:0]    item_addr;
  logic [ROW_AW-1:0]    rd_addr;
  logic [ROW_AW-1:0]    wr_addr;
  logic [COL_AW-1:0]    col_idx;
  logic                 in_grid;
  logic                 wr_en;

  assign row_ext   = RW'(row_q);
  assign item_addr = row_ext[ROW_AW-1:0];
  assign col_idx   = col_q[COL_AW-1:0];
  assign in_grid   = ({1'b0, row_ext} < (RW + 1)'(GRID_ROWS)) &&
                     ({1'b0, col_q} < (COORD_W + 1)'(GRID_COLS));

  assign rd_addr = cmd.rd_item ? item_addr : sweep_rd_addr;
  assign wr_addr = cmd.wr_item ? item_addr : sweep_wr_addr;
  assign wr_en   = cmd.wr_en && (!cmd.wr_item || in_grid);
  assign nxt_row = cmd.nxt_zero ? '0 : rd_data;

  assign pad_prev = {1'b0, prev_row, 1'b0};
  assign pad_cur  = {1'b0, cur_row, 1'b0};
  assign pad_nxt  = {1'b0, nxt_row, 1'b0};

  // B3/S23 over the three-row window; edges padded dead
  always_comb begin
    logic [NBR_W-1:0] nbr;
    life_row = '0;
    nbr      = '0;
    for (int c = 0; c < GRID_COLS; c++) begin
      nbr = NBR_W'(pad_prev[c]) + NBR_W'(pad_prev[c+1]) + NBR_W'(pad_prev[c+2]) +
            NBR_W'(pad_cur[c])                          + NBR_W'(pad_cur[c+2]) +
            NBR_W'(pad_nxt[c])  + NBR_W'(pad_nxt[c+1])  + NBR_W'(pad_nxt[c+2]);
      life_row[c] = (nbr == BIRTH_COUNT) || (pad_cur[c+1] && (nbr == SURVIVE_COUNT));
    end
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_SET:  wr_data = rd_data | (GRID_COLS'(1) << col_idx);
      WR_LIFE: wr_data = life_row;
      default: wr_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      row_q <= row;
      col_q <= col;
    end
    if (cmd.win_clear) begin
      prev_row <= '0;
      cur_row  <= '0;
    end else if (cmd.win_shift) begin
      prev_row <= cur_row;
      cur_row  <= nxt_row;
    end
    if (cmd.load_out) begin
      cell_alive <= rd_data[col_idx] & in_grid;
    end
  end

  lgs_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: src/lgs_ctrl.sv
`timescale 1ns / 1ps

module lgs_ctrl #(
  parameter int GRID_ROWS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lgs_pkg::OP_W-1:0]     op,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lgs_pkg::dp_cmd_t             cmd,
  output logic [$clog2(GRID_ROWS)-1:0] sweep_rd_addr,
  output logic [$clog2(GRID_ROWS)-1:0] sweep_wr_addr
);

  import lgs_pkg::*;

  localparam int ROW_AW = $clog2(GRID_ROWS);
  localparam int CNT_W  = $clog2(GRID_ROWS + 2);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SET_RD,
    S_SET_WR,
    S_STEP,
    S_FIN_RD,
    S_FIN_DATA
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_m2;
  logic             report;
  logic             out_free;

  assign in_stall      = (state != S_IDLE);
  assign out_free      = !out_valid || !out_stall;
  assign cnt_m2        = cnt - CNT_W'(2);
  assign sweep_rd_addr = cnt[ROW_AW-1:0];
  assign sweep_wr_addr = (state == S_STEP) ? cnt_m2[ROW_AW-1:0] : cnt[ROW_AW-1:0];

  always_comb begin
    cmd        = '0;
    cmd.wr_sel = WR_ZERO;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_en = 1'b1;
      end
      S_IDLE: begin
        cmd.load_item = in_valid;
        cmd.win_clear = 1'b1;
      end
      S_SET_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_item = 1'b1;
      end
      S_SET_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_item = 1'b1;
        cmd.wr_sel  = WR_SET;
      end
      S_STEP: begin
        cmd.rd_en     = (cnt < CNT_W'(GRID_ROWS));
        cmd.win_shift = (cnt >= CNT_W'(1));
        cmd.nxt_zero  = (cnt == CNT_W'(GRID_ROWS + 1));
        cmd.wr_en     = (cnt >= CNT_W'(2));
        cmd.wr_sel    = WR_LIFE;
      end
      S_FIN_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_item = 1'b1;
      end
      S_FIN_DATA: begin
        cmd.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      report    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ((state == S_FIN_DATA) && out_free) || (out_valid && out_stall);
      unique case (state)
        S_CLEAR: begin
          if (cnt == CNT_W'(GRID_ROWS - 1)) begin
            cnt    <= '0;
            report <= 1'b0;
            state  <= report ? S_FIN_RD : S_IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cnt <= '0;
            unique case (op_t'(op))
              OP_SET:   state <= S_SET_RD;
              OP_CLEAR: begin
                report <= 1'b1;
                state  <= S_CLEAR;
              end
              OP_STEP:  state <= S_STEP;
              OP_READ:  state <= S_FIN_RD;
            endcase
          end
        end
        S_SET_RD: state <= S_SET_WR;
        S_SET_WR: state <= S_FIN_RD;
        S_STEP: begin
          if (cnt == CNT_W'(GRID_ROWS + 1)) begin
            cnt   <= '0;
            state <= S_FIN_RD;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_FIN_RD: state <= S_FIN_DATA;
        S_FIN_DATA: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_locks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in progress");

  a_step_no_clash: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) && cmd.rd_en && cmd.wr_en |-> sweep_rd_addr != sweep_wr_addr)
    else $error("step sweep reads and writes the same row");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN_DATA))
    else $error("result beat raised outside final read");

  a_sweep_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) && (cnt == CNT_W'(GRID_ROWS + 1)) |=> state == S_FIN_RD)
    else $error("step sweep did not end in final read");

endmodule

// File: tb/sv/tb_life_grid_generation_step_top.sv
`timescale 1ns / 1ps

module tb_life_grid_generation_step_top;
  import lgs_pkg::*;

  localparam int ROWS       = DEF_GRID_ROWS;
  localparam int COLS       = DEF_GRID_COLS;
  localparam int RAND_ITEMS = 1750;
  localparam int PHASE_LEN  = 110;
  localparam int HANG_LIMIT = 3000;
  localparam int DRAIN_CYC  = 80;

  typedef struct {
    op_t          op;
    logic [5:0]   row;
    logic [5:0]   col;
  } life_op_t;

  typedef struct {
    op_t          op;
    logic [5:0]   row;
    logic [5:0]   col;
    logic         alive;
  } alive_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] op = '0;
  logic [COORD_W-1:0] row = '0;
  logic [COORD_W-1:0] col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cell_alive;

  logic [COLS-1:0] life_grid [ROWS];
  life_op_t   op_pending_q [$];
  alive_exp_t alive_exp_q [$];
  life_op_t   next_op;
  alive_exp_t got_exp;

  int beats_in = 0;
  int ops_total = 0;
  int mismatches = 0;
  int hang_cnt = 0;
  int phase;
  int idle_pct;
  int stall_pct;

  assign phase     = (beats_in / PHASE_LEN) % 4;
  assign idle_pct  = (phase == 1) ? 57 : (phase == 3) ? 29 : 0;
  assign stall_pct = (phase == 2) ? 57 : (phase == 3) ? 29 : 0;

  life_grid_generation_step_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .row        (row),
    .col        (col),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_alive (cell_alive)
  );

  always #6 clk = ~clk;

  function automatic int cell_at(int r, int c);
    if (r < 0 || r >= ROWS || c < 0 || c >= COLS) return 0;
    return int'(life_grid[r][c]);
  endfunction

  // B3/S23, cells off the edge are dead
  function automatic logic life_apply(op_t o, logic [5:0] r, logic [5:0] c);
    logic [COLS-1:0] nxt [ROWS];
    int n;
    logic on_grid;
    on_grid = (int'(r) < ROWS) && (int'(c) < COLS);
    case (o)
      OP_SET: begin
        if (on_grid) life_grid[r][c] = 1'b1;
      end
      OP_CLEAR: begin
        for (int i = 0; i < ROWS; i++) life_grid[i] = '0;
      end
      OP_STEP: begin
        for (int i = 0; i < ROWS; i++) begin
          for (int j = 0; j < COLS; j++) begin
            n = 0;
            for (int di = -1; di <= 1; di++)
              for (int dj = -1; dj <= 1; dj++)
                if (di != 0 || dj != 0) n += cell_at(i + di, j + dj);
            nxt[i][j] = life_grid[i][j] ? (n == 2 || n == 3) : (n == 3);
          end
        end
        for (int i = 0; i < ROWS; i++) life_grid[i] = nxt[i];
      end
      default: ;
    endcase
    return on_grid ? life_grid[r][c] : 1'b0;
  endfunction

  task automatic queue_op(op_t o, int r, int c);
    life_op_t it;
    it.op  = o;
    it.row = r[5:0];
    it.col = c[5:0];
    op_pending_q.push_back(it);
    ops_total++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatches++;
  endtask

  // origin of a 5x5 box, often hugging an edge
  function automatic int box_base();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 59;
      default: return $urandom_range(0, 59);
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        got_exp.op    = op_t'(op);
        got_exp.row   = row;
        got_exp.col   = col;
        got_exp.alive = life_apply(op_t'(op), row, col);
        alive_exp_q.push_back(got_exp);
        beats_in <= beats_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (op_pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          next_op = op_pending_q.pop_front();
          in_valid <= 1'b1;
          op <= next_op.op;
          row <= next_op.row;
          col <= next_op.col;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (alive_exp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat cell_alive=%0b", cell_alive));
        end else begin
          got_exp = alive_exp_q.pop_front();
          if (cell_alive !== got_exp.alive)
            report_mismatch($sformatf("%s r=%0d c=%0d cell_alive=%0b want %0b",
                                      got_exp.op.name(), got_exp.row, got_exp.col,
                                      cell_alive, got_exp.alive));
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cnt <= 0;
    end else if (hang_cnt >= HANG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      hang_cnt <= hang_cnt + 1;
    end
  end

  initial begin
    int r0, c0, nrand;
    for (int i = 0; i < ROWS; i++) life_grid[i] = '0;

    // directed: corners, isolated death, corner block, edge blinker
    queue_op(OP_READ, 0, 0);
    queue_op(OP_SET, 0, 0);
    queue_op(OP_SET, 0, 63);
    queue_op(OP_SET, 63, 0);
    queue_op(OP_READ, 63, 63);
    queue_op(OP_SET, 63, 63);
    queue_op(OP_READ, 0, 63);
    queue_op(OP_STEP, 0, 0);
    queue_op(OP_READ, 63, 63);
    queue_op(OP_SET, 62, 62);
    queue_op(OP_SET, 62, 63);
    queue_op(OP_SET, 63, 62);
    queue_op(OP_SET, 63, 63);
    queue_op(OP_SET, 0, 30);
    queue_op(OP_SET, 0, 31);
    queue_op(OP_SET, 0, 32);
    queue_op(OP_STEP, 1, 31);
    queue_op(OP_READ, 0, 30);
    queue_op(OP_STEP, 0, 31);
    queue_op(OP_READ, 63, 63);
    queue_op(OP_CLEAR, 63, 63);
    queue_op(OP_READ, 62, 62);
    queue_op(OP_STEP, 63, 0);

    nrand = 0;
    while (nrand < RAND_ITEMS) begin
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        // seed a small pattern, evolve it, look around it
        r0 = box_base();
        c0 = box_base();
        repeat ($urandom_range(3, 10)) begin
          queue_op(OP_SET, r0 + $urandom_range(0, 4), c0 + $urandom_range(0, 4));
          nrand++;
        end
        repeat ($urandom_range(1, 4)) begin
          queue_op(OP_STEP, r0 + $urandom_range(0, 4), c0 + $urandom_range(0, 4));
          nrand++;
        end
        repeat ($urandom_range(1, 4)) begin
          queue_op(OP_READ, r0 + $urandom_range(0, 4), c0 + $urandom_range(0, 4));
          nrand++;
        end
      end else if (pick < 92) begin
        queue_op(op_t'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63));
        nrand++;
      end else begin
        queue_op(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
        nrand++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (beats_in != ops_total) @(posedge clk);
    while (alive_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
